// ----- rtl/core/jet_pkg.sv -----
package jet_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 28;
	localparam int ITER_BITS  = 12;

	localparam int GRAY_BITS  = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int ORIGIN_W   = 32;
	localparam int STEP_W     = 31;
	localparam int SEED_W     = 32;

	localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((GRAY_BITS + ITER_BITS + 7) / 8) * 8;

	// start point width and width after an update, z register takes the larger
	localparam int ZW_START = COORD_BITS + STEP_W + 2;
	localparam int ZW_UPD   = FRAC_BITS + 5;
	localparam int ZW       = (ZW_START > ZW_UPD) ? ZW_START : ZW_UPD;
	localparam int MW       = FRAC_BITS + 2;
	localparam int PW       = 2 * MW;
	localparam int PX_W     = COORD_BITS + STEP_W;
	localparam int NUM_W    = ITER_BITS + GRAY_BITS;

	localparam int DIV_STEPS = GRAY_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic signed [ZW-1:0] Z_LIM = ZW'(1) << (FRAC_BITS + 1);
	localparam logic [PW-1:0] MAG_FOUR = PW'(1) << (2 * FRAC_BITS + 2);
	localparam logic [ITER_BITS-1:0] MAX_ITER_RST = ITER_BITS'(128);

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_REAL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_IMAG   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd6;

	typedef struct packed {
		logic signed [ORIGIN_W-1:0] origin_real;
		logic signed [ORIGIN_W-1:0] origin_imag;
		logic [STEP_W-1:0]          step_real;
		logic [STEP_W-1:0]          step_imag;
		logic signed [SEED_W-1:0]   seed_real;
		logic signed [SEED_W-1:0]   seed_imag;
		logic [ITER_BITS-1:0]       max_iterations;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic upd;
		logic finish;
		logic esc;
		logic div_step;
		logic out_write;
	} cmd_t;

	typedef struct packed {
		logic at_max;
		logic out_range;
		logic sum_esc;
		logic out_busy;
	} status_t;

endpackage

// ----- rtl/core/jet_cfg.sv -----
module jet_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [jet_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [jet_pkg::CFG_DATA_W-1:0]  cfg_data,
	output jet_pkg::cfg_t                   cfg
);
	import jet_pkg::*;

	cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign cfg       = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.origin_real    <= '0;
			regs_q.origin_imag    <= '0;
			regs_q.step_real      <= '0;
			regs_q.step_imag      <= '0;
			regs_q.seed_real      <= '0;
			regs_q.seed_imag      <= '0;
			regs_q.max_iterations <= MAX_ITER_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ORIGIN_REAL: regs_q.origin_real <= cfg_data[ORIGIN_W-1:0];
				REG_ORIGIN_IMAG: regs_q.origin_imag <= cfg_data[ORIGIN_W-1:0];
				REG_STEP_REAL:   regs_q.step_real   <= cfg_data[STEP_W-1:0];
				REG_STEP_IMAG:   regs_q.step_imag   <= cfg_data[STEP_W-1:0];
				REG_SEED_REAL:   regs_q.seed_real   <= cfg_data[SEED_W-1:0];
				REG_SEED_IMAG:   regs_q.seed_imag   <= cfg_data[SEED_W-1:0];
				REG_MAX_ITER:    regs_q.max_iterations <= cfg_data[ITER_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/jet_dp.sv -----
module jet_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  jet_pkg::cfg_t                    cfg,
	input  jet_pkg::cmd_t                    cmd,
	output jet_pkg::status_t                 status,
	input  logic [jet_pkg::IN_TDATA_W-1:0]   in_data,
	input  logic                             in_last,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [jet_pkg::OUT_TDATA_W-1:0]  out_data,
	output logic                             out_user,
	output logic                             out_last
);
	import jet_pkg::*;

	logic [COORD_BITS-1:0]    px_col, px_row;
	logic [PX_W-1:0]          prod_col, prod_row;
	logic signed [ZW-1:0]     zr_start, zi_start, zr_next, zi_next;
	logic signed [ZW-1:0]     zr_q, zi_q;
	logic signed [MW-1:0]     zr_m, zi_m;
	logic signed [PW-1:0]     qr_q, qi_q, cr_q, diff;
	logic [PW-1:0]            mag_sum;
	logic [ITER_BITS-1:0]     cnt_q;
	logic                     esc_q, last_q;
	logic [NUM_W-1:0]         rem_q, dvs_q, num;
	logic [GRAY_BITS-1:0]     quo_q;
	logic [GRAY_BITS-1:0]     gray_out_q;
	logic [ITER_BITS-1:0]     cnt_out_q;
	logic                     esc_out_q, last_out_q, valid_q;

	assign px_col = in_data[COORD_BITS-1:0];
	assign px_row = in_data[2*COORD_BITS-1:COORD_BITS];

	assign prod_col = {{STEP_W{1'b0}}, px_col} * {{COORD_BITS{1'b0}}, cfg.step_real};
	assign prod_row = {{STEP_W{1'b0}}, px_row} * {{COORD_BITS{1'b0}}, cfg.step_imag};
	assign zr_start = ZW'(cfg.origin_real) + signed'(ZW'(prod_col));
	assign zi_start = ZW'(cfg.origin_imag) + signed'(ZW'(prod_row));

	assign zr_m = zr_q[MW-1:0];
	assign zi_m = zi_q[MW-1:0];

	// floor by arithmetic shift; the cross term carries the factor of two
	assign mag_sum = qr_q + qi_q;
	assign diff    = qr_q - qi_q;
	assign zr_next = ZW'(diff >>> FRAC_BITS) + ZW'(cfg.seed_real);
	assign zi_next = ZW'(cr_q >>> (FRAC_BITS - 1)) + ZW'(cfg.seed_imag);

	// count * 255
	assign num = {cnt_q, {GRAY_BITS{1'b0}}} - NUM_W'(cnt_q);

	assign status.at_max    = (cnt_q == cfg.max_iterations);
	assign status.out_range = !((zr_q > -Z_LIM) && (zr_q < Z_LIM) &&
	                            (zi_q > -Z_LIM) && (zi_q < Z_LIM));
	assign status.sum_esc   = (mag_sum >= MAG_FOUR);
	assign status.out_busy  = valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zr_q   <= zr_start;
			zi_q   <= zi_start;
			cnt_q  <= '0;
			last_q <= in_last;
		end else if (cmd.upd) begin
			zr_q  <= zr_next;
			zi_q  <= zi_next;
			cnt_q <= cnt_q + ITER_BITS'(1);
		end
		if (cmd.mul) begin
			qr_q <= zr_m * zr_m;
			qi_q <= zi_m * zi_m;
			cr_q <= zr_m * zi_m;
		end
		if (cmd.finish) begin
			esc_q <= cmd.esc;
			rem_q <= cmd.esc ? num : '0;
			dvs_q <= NUM_W'(cfg.max_iterations) << (GRAY_BITS - 1);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= dvs_q) begin
				rem_q <= rem_q - dvs_q;
				quo_q <= {quo_q[GRAY_BITS-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[GRAY_BITS-2:0], 1'b0};
			end
			dvs_q <= dvs_q >> 1;
		end
		if (cmd.out_write) begin
			gray_out_q <= esc_q ? quo_q : '0;
			cnt_out_q  <= cnt_q;
			esc_out_q  <= esc_q;
			last_out_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_write) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = OUT_TDATA_W'({cnt_out_q, gray_out_q});
	assign out_user  = esc_out_q;
	assign out_last  = last_out_q;

endmodule

// ----- rtl/core/jet_ctrl.sv -----
module jet_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  jet_pkg::status_t  status,
	output jet_pkg::cmd_t     cmd
);
	import jet_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_UPD   = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t               state_q, state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (status.at_max) begin
					cmd.finish = 1'b1;
					state_d    = ST_DIV;
				end else if (status.out_range) begin
					cmd.finish = 1'b1;
					cmd.esc    = 1'b1;
					state_d    = ST_DIV;
				end else begin
					cmd.mul = 1'b1;
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (status.sum_esc) begin
					cmd.finish = 1'b1;
					cmd.esc    = 1'b1;
					state_d    = ST_DIV;
				end else begin
					cmd.upd = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == '0) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!status.out_busy) begin
					cmd.out_write = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				div_cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/julia_escape_time_pixel.sv -----
// Flow: a request is accepted in idle; each pass of the z loop tests z against its
// bound and n against max_iterations, then tests |z|^2 and updates z; n = iterations
// done (n <= max_iterations). The gray level then comes from a bit-serial divide.
// The result is written to the output register once that register is free; the next
// request is taken while the previous result waits in the output register.
// Reset: arst_n clears the controller, output valid and config registers
// (max_iterations = 128, all others 0).
module julia_escape_time_pixel (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [jet_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // pixel_column, pixel_row
	input  logic                             s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [jet_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // gray_level, iteration_count
	output logic                             m_axis_tuser,   // escaped
	output logic                             m_axis_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [jet_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jet_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import jet_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	jet_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	jet_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	jet_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule
